@@ rtl/sync_word_frame_receiver_macros.svh @@
// Assertion helpers shared by the receiver RTL.
`ifndef SYNC_WORD_FRAME_RECEIVER_MACROS_SVH
`define SYNC_WORD_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk unless rst is high.
`define SWFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop at every rising edge of clk, reset included.
`define SWFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWFR_ASSERT(label, clk, rst, prop, msg)
`define SWFR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/swfr_pkg.sv @@
package swfr_pkg;

   localparam int STORE_DEPTH_DEF = 512;

   localparam int WORD_W  = 16;
   localparam int INDEX_W = 9;

   // operation codes
   localparam logic [1:0] OP_WORD    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_CODE_DISPLAY = 2'd0;
   localparam logic [1:0] CSR_CODE_TOUCH   = 2'd1;
   localparam logic [1:0] CSR_CODE_PINS    = 2'd2;

   // frame classes
   localparam logic [1:0] CLASS_DISPLAY = 2'd0;
   localparam logic [1:0] CLASS_TOUCH   = 2'd1;
   localparam logic [1:0] CLASS_PINS    = 2'd2;
   localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

   // receive phases
   localparam logic [2:0] PHASE_SYNC0 = 3'd0;
   localparam logic [2:0] PHASE_REG   = 3'd4;
   localparam logic [2:0] PHASE_LEN   = 3'd5;
   localparam logic [2:0] PHASE_DATA  = 3'd6;

   // sync header: FFFF, FFFE, FFFD, FFFC
   localparam logic [7:0] SYNC_HIGH = 8'hFF;
   localparam logic [3:0][7:0] SYNC_LOW = {8'hFC, 8'hFD, 8'hFE, 8'hFF};

   typedef struct packed {
      logic              frame_done;
      logic              frame_held;
      logic [WORD_W-1:0] frame_register;
      logic [WORD_W-1:0] frame_length;
      logic [1:0]        frame_class;
      logic              read_en;
   } status_type;

   function automatic logic [WORD_W-1:0] sync_word(input logic [1:0] slot);
      sync_word = {SYNC_HIGH, SYNC_LOW[slot]};
   endfunction

   function automatic logic [1:0] classify(input logic [WORD_W-1:0] reg_word,
                                           input logic [WORD_W-1:0] c_display,
                                           input logic [WORD_W-1:0] c_touch,
                                           input logic [WORD_W-1:0] c_pins);
      priority if (reg_word == c_display) classify = CLASS_DISPLAY;
      else if (reg_word == c_touch)       classify = CLASS_TOUCH;
      else if (reg_word == c_pins)        classify = CLASS_PINS;
      else                                classify = CLASS_UNKNOWN;
   endfunction

endpackage

@@ rtl/sync_word_frame_receiver.sv @@
// Sync-word framed receiver.
// Request channel (req_*): one beat per operation. op WORD delivers a received
// byte pair, op READ fetches a stored data word by req_read_index, op RELEASE
// frees a held frame. Every request beat yields exactly one response beat
// (rsp_*) with the frame status, the read word (zero unless a READ inside the
// frame length) and the class of the latest register word.
// A frame is the header FFFF FFFE FFFD FFFC, a register word, a length word and
// max(length,1) data words; data words land in a single-port-write store of
// STORE_DEPTH entries (registered read), positions past the depth are
// dropped. A finished frame is held and later words are ignored until release.
// The request beat and its store read are registered in the middle stage, then
// move to the output register. Throughput: one beat per cycle while rsp_stall
// does not back the pipeline up, with a single store access per request.
// Stalls: the output register and the stage in front of it form a two-deep
// buffer; the request side stalls only when both are full and rsp_stall holds.
// Reset (synchronous) empties the pipeline, returns to sync search, clears
// the held frame and loads the class codes 1, 2 and 3. The store is not
// cleared; no clearing pass is needed.
// Configuration: csr_write, csr_index, csr_data; write only while idle.
`include "sync_word_frame_receiver_macros.svh"

module sync_word_frame_receiver #(
   parameter int STORE_DEPTH = swfr_pkg::STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_byte_high,
   input  logic [7:0]  req_byte_low,
   input  logic [8:0]  req_read_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_done,
   output logic        rsp_frame_held,
   output logic [15:0] rsp_frame_register,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_read_word,
   output logic [1:0]  rsp_frame_class,
   output logic        rsp_ready_line
);
   import swfr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(STORE_DEPTH);

   // configuration registers
   logic [WORD_W-1:0] code_display_ff, code_touch_ff, code_pins_ff;

   // frame state
   logic [2:0]        phase_ff, phase_in;
   logic              held_ff, held_in;
   logic [WORD_W-1:0] reg_word_ff, reg_word_in;
   logic [WORD_W-1:0] length_ff, length_in;
   logic [WORD_W-1:0] position_ff, position_in;

   // pipeline
   logic              mid_valid_ff, mid_valid_in;
   status_type        mid_ff, mid_in;
   logic [WORD_W-1:0] mem_q_ff;
   logic              out_valid_ff, out_valid_in;
   status_type        out_ff;
   logic [WORD_W-1:0] out_word_ff;

   logic [WORD_W-1:0] word_store [STORE_DEPTH];

   logic              req_accept, rsp_accept, mid_move;
   logic [WORD_W-1:0] rx_word, read_index_w, need, position_next;
   logic              done_in, mem_we, read_en;

   assign rx_word      = {req_byte_high, req_byte_low};
   assign read_index_w = WORD_W'(req_read_index);

   // advance the middle stage when the output register is free or draining
   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign mid_move   = mid_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = mid_valid_ff && !mid_move;
   assign req_accept = req_valid && !req_stall;

   assign need          = (length_ff == '0) ? WORD_W'(1) : length_ff;
   assign position_next = position_ff + WORD_W'(1);

   // frame parser
   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      reg_word_in = reg_word_ff;
      length_in   = length_ff;
      position_in = position_ff;
      done_in     = 1'b0;
      mem_we      = 1'b0;
      read_en     = 1'b0;
      unique case (req_op)
         OP_WORD: begin
            if (!held_ff) begin
               priority if (phase_ff < PHASE_REG) begin
                  // mismatch drops back to the start without rechecking
                  if (rx_word == sync_word(phase_ff[1:0])) begin
                     phase_in = phase_ff + 3'd1;
                  end else begin
                     phase_in = PHASE_SYNC0;
                  end
               end else if (phase_ff == PHASE_REG) begin
                  reg_word_in = rx_word;
                  phase_in    = PHASE_LEN;
               end else if (phase_ff == PHASE_LEN) begin
                  length_in   = rx_word;
                  position_in = '0;
                  phase_in    = PHASE_DATA;
               end else begin
                  mem_we      = position_ff < DEPTH_W;
                  position_in = position_next;
                  if (position_next >= need) begin
                     phase_in = PHASE_SYNC0;
                     held_in  = 1'b1;
                     done_in  = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            read_en = (read_index_w < length_ff) && (read_index_w < DEPTH_W);
         end
         OP_RELEASE: begin
            held_in = 1'b0;
         end
         default: begin
            // unused op: report status as it stands
         end
      endcase
   end

   always_comb begin
      mid_in.frame_done     = done_in;
      mid_in.frame_held     = held_in;
      mid_in.frame_register = reg_word_in;
      mid_in.frame_length   = length_in;
      mid_in.frame_class    = classify(reg_word_in, code_display_ff, code_touch_ff,
                                       code_pins_ff);
      mid_in.read_en        = read_en;
   end

   always_comb begin
      priority if (req_accept)  mid_valid_in = 1'b1;
      else if (mid_move)        mid_valid_in = 1'b0;
      else                      mid_valid_in = mid_valid_ff;
      priority if (mid_move)    out_valid_in = 1'b1;
      else if (rsp_accept)      out_valid_in = 1'b0;
      else                      out_valid_in = out_valid_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_display_ff <= WORD_W'(1);
         code_touch_ff   <= WORD_W'(2);
         code_pins_ff    <= WORD_W'(3);
         phase_ff        <= PHASE_SYNC0;
         held_ff         <= 1'b0;
         reg_word_ff     <= '0;
         length_ff       <= '0;
         position_ff     <= '0;
         mid_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_CODE_DISPLAY: code_display_ff <= csr_data;
               CSR_CODE_TOUCH:   code_touch_ff   <= csr_data;
               CSR_CODE_PINS:    code_pins_ff    <= csr_data;
               default: begin
                  // no register here: drop the write
               end
            endcase
         end
         if (req_accept) begin
            phase_ff    <= phase_in;
            held_ff     <= held_in;
            reg_word_ff <= reg_word_in;
            length_ff   <= length_in;
            position_ff <= position_in;
         end
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_ff <= mid_in;
      end
      if (mid_move) begin
         out_ff      <= mid_ff;
         out_word_ff <= mid_ff.read_en ? mem_q_ff : '0;
      end
   end

   // word store: one write or one read per request, never both
   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         word_store[position_ff[ADDR_W-1:0]] <= rx_word;
      end
      if (req_accept && read_en) begin
         mem_q_ff <= word_store[read_index_w[ADDR_W-1:0]];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_held     = out_ff.frame_held;
   assign rsp_frame_register = out_ff.frame_register;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_read_word      = out_word_ff;
   assign rsp_frame_class    = out_ff.frame_class;
   assign rsp_ready_line     = !out_ff.frame_held;

   `SWFR_ASSERT(a_no_store_write_held, clock, reset,
                (req_accept && mem_we) |-> !held_ff, "store written while a frame is held")
   `SWFR_ASSERT(a_done_from_data, clock, reset,
                (req_accept && done_in) |-> (phase_ff == PHASE_DATA),
                "frame completed outside the data phase")
   `SWFR_ASSERT(a_done_holds, clock, reset,
                (rsp_valid && rsp_frame_done) |-> (rsp_frame_held && !rsp_ready_line),
                "completed frame not reported as held")
   `SWFR_ASSERT(a_read_in_length, clock, reset,
                (rsp_valid && rsp_read_word != '0) |-> (rsp_frame_length != '0),
                "read word returned for an empty frame")
   `SWFR_ASSERT(a_release_clears, clock, reset,
                (req_accept && req_op == OP_RELEASE) |=> !held_ff,
                "release left the frame held")
   `SWFR_ASSERT_ALWAYS(a_stall_only_full, clock,
                       req_stall |-> mid_valid_ff, "request stalled with the middle stage empty")

endmodule

@@ verif/sync_word_frame_receiver_checker.sv @@
// Watches both channels of the receiver, keeps its own copy of the framing
// state and the store, and compares every response beat against the oldest
// predicted status.
module sync_word_frame_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_byte_high,
   input  logic [7:0]  req_byte_low,
   input  logic [8:0]  req_read_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_frame_done,
   input  logic        rsp_frame_held,
   input  logic [15:0] rsp_frame_register,
   input  logic [15:0] rsp_frame_length,
   input  logic [15:0] rsp_read_word,
   input  logic [1:0]  rsp_frame_class,
   input  logic        rsp_ready_line,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import swfr_pkg::*;

   localparam int DEPTH = STORE_DEPTH_DEF;
   localparam int REPORT_LIMIT = 10;
   localparam logic [15:0] HEADER_WORDS [4] = '{16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFC};

   typedef struct packed {
      logic        done;
      logic        held;
      logic [15:0] reg_word;
      logic [15:0] length_word;
      logic [15:0] read_word;
      logic [1:0]  frame_class;
      logic        ready;
   } frame_status_type;

   logic [15:0] code_display_q, code_touch_q, code_pins_q;
   logic [2:0]  rx_phase;
   logic        rx_held;
   logic        rx_ready;
   logic [15:0] rx_register;
   logic [15:0] rx_length;
   logic [15:0] rx_position;
   logic [15:0] rx_store [DEPTH];

   frame_status_type expected_status_q [$];

   function automatic logic [1:0] class_of(input logic [15:0] reg_word);
      if (reg_word == code_display_q) return CLASS_DISPLAY;
      if (reg_word == code_touch_q) return CLASS_TOUCH;
      if (reg_word == code_pins_q) return CLASS_PINS;
      return CLASS_UNKNOWN;
   endfunction

   // Advance the framing state by one received word; 1 when it ends a frame.
   function automatic logic accept_word(input logic [15:0] w);
      logic [16:0] need;
      if (rx_held) return 1'b0;
      if (rx_phase < PHASE_REG) begin
         if (w == HEADER_WORDS[rx_phase[1:0]]) rx_phase = rx_phase + 3'd1;
         else rx_phase = PHASE_SYNC0;
         return 1'b0;
      end
      if (rx_phase == PHASE_REG) begin
         rx_register = w;
         rx_phase = PHASE_LEN;
         return 1'b0;
      end
      if (rx_phase == PHASE_LEN) begin
         rx_length = w;
         rx_position = 16'd0;
         rx_phase = PHASE_DATA;
         return 1'b0;
      end
      need = (rx_length == 16'd0) ? 17'd1 : {1'b0, rx_length};
      // drop words past the end of the store, but keep counting them
      if (rx_position < DEPTH) rx_store[rx_position] = w;
      rx_position = rx_position + 16'd1;
      if ({1'b0, rx_position} >= need) begin
         rx_phase = PHASE_SYNC0;
         rx_held = 1'b1;
         rx_ready = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic frame_status_type predict_status(input logic [1:0] op,
                                                       input logic [15:0] w,
                                                       input logic [8:0] idx);
      frame_status_type s;
      s = '0;
      case (op)
         OP_WORD: s.done = accept_word(w);
         OP_READ: if (idx < rx_length && idx < DEPTH) s.read_word = rx_store[idx];
         OP_RELEASE: begin
            rx_held = 1'b0;
            rx_ready = 1'b1;
         end
         default: ;
      endcase
      s.held = rx_held;
      s.reg_word = rx_register;
      s.length_word = rx_length;
      s.frame_class = class_of(rx_register);
      s.ready = rx_ready;
      return s;
   endfunction

   always @(posedge clock) begin
      frame_status_type got;
      frame_status_type want;
      if (reset) begin
         code_display_q = 16'd1;
         code_touch_q = 16'd2;
         code_pins_q = 16'd3;
         rx_phase = PHASE_SYNC0;
         rx_held = 1'b0;
         rx_ready = 1'b1;
         rx_register = 16'd0;
         rx_length = 16'd0;
         rx_position = 16'd0;
         expected_status_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.done = rsp_frame_done;
            got.held = rsp_frame_held;
            got.reg_word = rsp_frame_register;
            got.length_word = rsp_frame_length;
            got.read_word = rsp_read_word;
            got.frame_class = rsp_frame_class;
            got.ready = rsp_ready_line;
            if (expected_status_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: response beat with no request pending (register %h)",
                           $realtime, got.reg_word);
               fail_count++;
            end else begin
               want = expected_status_q.pop_front();
               if (got !== want) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: expected done %b held %b reg %h len %h rd %h class %0d rdy %b",
                              $realtime, want.done, want.held, want.reg_word,
                              want.length_word, want.read_word, want.frame_class,
                              want.ready);
                     $display("%0t: actual   done %b held %b reg %h len %h rd %h class %0d rdy %b",
                              $realtime, got.done, got.held, got.reg_word,
                              got.length_word, got.read_word, got.frame_class,
                              got.ready);
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_status_q.push_back(predict_status(req_op, {req_byte_high, req_byte_low},
                                                       req_read_index));
         if (csr_write) begin
            case (csr_index)
               CSR_CODE_DISPLAY: code_display_q = csr_data;
               CSR_CODE_TOUCH: code_touch_q = csr_data;
               CSR_CODE_PINS: code_pins_q = csr_data;
               default: ;
            endcase
         end
      end
      pending_count = expected_status_q.size();
   end

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swfr_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 560;
   localparam int PHASE_COUNT = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 8;
   // op value the block leaves undefined
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // longer than the store, so the tail of the frame overflows it
   localparam logic [15:0] FILL_LENGTH = 16'd520;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [7:0]  req_byte_high;
   logic [7:0]  req_byte_low;
   logic [8:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_frame_done;
   logic        rsp_frame_held;
   logic [15:0] rsp_frame_register;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_read_word;
   logic [1:0]  rsp_frame_class;
   logic        rsp_ready_line;
   int          fail_count;
   int          pending_count;

   idle_mode_type idle_mode;
   logic        hold_trigger;
   logic        hold_served;
   int          beat_count;
   int          last_length;
   // class codes as last written, used to aim register words at them
   logic [15:0] code_display_w, code_touch_w, code_pins_w;

   sync_word_frame_receiver dut (.*);

   sync_word_frame_receiver_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: end the run if the traffic never drains.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic logic sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 79;
         IDLE_BOTH: return $urandom_range(0, 99) < 26;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 79;
         IDLE_BOTH: return $urandom_range(0, 99) < 26;
         default: return 1'b0;
      endcase
   endfunction

   // Response side: stall at random per the idle mode; once triggered, hold off
   // for a long counted stretch so the block fills and stalls its request side.
   initial begin
      rsp_stall = 1'b0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger && !hold_served) begin
            rsp_stall <= 1'b1;
            for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clock);
            hold_served <= 1'b1;
         end else begin
            rsp_stall <= receiver_stalls();
         end
      end
   end

   // Offer one beat and hold it until accepted. Sample the stall at the falling
   // edge, where it is settled, and return right after the accepting edge.
   task automatic send_beat(input logic [1:0] op, input logic [7:0] hi, input logic [7:0] lo,
                            input logic [8:0] idx);
      logic stalled;
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_byte_high <= hi;
      req_byte_low <= lo;
      req_read_index <= idx;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      beat_count++;
   endtask

   // Unused fields carry random values so every input bit toggles.
   task automatic send_word(input logic [15:0] w);
      send_beat(OP_WORD, w[15:8], w[7:0], 9'($urandom));
   endtask

   task automatic send_read(input logic [8:0] idx);
      send_beat(OP_READ, 8'($urandom), 8'($urandom), idx);
   endtask

   task automatic send_release();
      send_beat(OP_RELEASE, 8'($urandom), 8'($urandom), 9'($urandom));
   endtask

   task automatic send_header();
      for (int slot = 0; slot < 4; slot++) send_word({SYNC_HIGH, SYNC_LOW[slot]});
   endtask

   // Send a full frame with random data; optionally slip reads between data words.
   task automatic send_frame(input logic [15:0] reg_w, input logic [15:0] len,
                             input bit reads_inside);
      int n;
      n = (len == 16'd0) ? 1 : int'(len);
      send_header();
      send_word(reg_w);
      send_word(len);
      for (int i = 0; i < n; i++) begin
         send_word(16'($urandom));
         if (reads_inside && $urandom_range(0, 9) == 0) send_read(9'($urandom));
      end
   endtask

   function automatic logic [15:0] pick_register();
      case ($urandom_range(0, 3))
         0: return code_display_w;
         1: return code_touch_w;
         2: return code_pins_w;
         default: return 16'($urandom);
      endcase
   endfunction

   // Reads half the time around the current frame length, the rest anywhere.
   function automatic logic [8:0] pick_index();
      if ($urandom_range(0, 1))
         return 9'($urandom_range(0, (last_length > 510) ? 511 : last_length + 1));
      return 9'($urandom);
   endfunction

   // Drain the block, let it settle, then load all three class codes.
   task automatic write_codes(input logic [15:0] d, input logic [15:0] t, input logic [15:0] p);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_CODE_DISPLAY;
      csr_data <= d;
      @(posedge clock);
      csr_index <= CSR_CODE_TOUCH;
      csr_data <= t;
      @(posedge clock);
      csr_index <= CSR_CODE_PINS;
      csr_data <= p;
      @(posedge clock);
      csr_write <= 1'b0;
      code_display_w = d;
      code_touch_w = t;
      code_pins_w = p;
   endtask

   // One random burst: mostly well-formed frames, the rest loose ops, broken
   // headers and stray words.
   task automatic random_burst();
      int pick;
      int cut;
      logic [15:0] len;
      logic [15:0] w;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                           : 16'($urandom_range(0, 8));
         send_frame(pick_register(), len, 1'b1);
         last_length = int'(len);
         repeat ($urandom_range(0, 3)) send_read(pick_index());
         // now and then leave the frame held so the next words get ignored
         if ($urandom_range(0, 9) != 0) send_release();
         else send_word(16'($urandom));
      end else if (pick < 75) begin
         case ($urandom_range(0, 3))
            0, 1: send_read(pick_index());
            2: send_release();
            default: send_beat(OP_UNUSED, 8'($urandom), 8'($urandom), 9'($urandom));
         endcase
      end else if (pick < 90) begin
         // break the header after one to three good words
         cut = $urandom_range(1, 3);
         for (int slot = 0; slot < cut; slot++) send_word({SYNC_HIGH, SYNC_LOW[slot]});
         w = 16'($urandom);
         if (w == {SYNC_HIGH, SYNC_LOW[cut]}) w = w ^ 16'd1;
         send_word(w);
      end else begin
         if ($urandom_range(0, 1)) send_word({SYNC_HIGH, SYNC_LOW[$urandom_range(0, 3)]});
         else send_word(16'($urandom));
      end
   endtask

   initial begin
      int phase_start;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_CODE_DISPLAY;
      csr_data = 16'd0;
      req_valid = 1'b0;
      req_op = OP_WORD;
      req_byte_high = 8'd0;
      req_byte_low = 8'd0;
      req_read_index = 9'd0;
      idle_mode = IDLE_NONE;
      hold_trigger = 1'b0;
      beat_count = 0;
      last_length = 0;
      code_display_w = 16'd1;
      code_touch_w = 16'd2;
      code_pins_w = 16'd3;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: status ops on an empty receiver, with reset codes in place.
      send_beat(OP_UNUSED, 8'hFF, 8'h00, 9'd511);
      send_read(9'd0);
      send_read(9'd511);
      send_release();
      // Break the header at its third word with a first sync word; it must not
      // restart the header, so the full header that follows is what syncs.
      send_word(16'hFFFF);
      send_word(16'hFFFE);
      send_word(16'hFFFF);
      // Zero-length display frame still takes one data word.
      send_header();
      send_word(16'd1);
      send_word(16'd0);
      send_word(16'hFFFF);
      // Ignore words while held; reads see length zero.
      send_word(16'hFFFF);
      send_read(9'd0);
      send_release();
      // Unknown register, three words; read inside and just past the length.
      send_header();
      send_word(16'hFFFF);
      send_word(16'd3);
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'h8001);
      send_release();
      send_read(9'd2);
      send_read(9'd3);

      // Fill every store entry with one frame that overruns the store, so no
      // later read can land on a never-written entry.
      send_frame(pick_register(), FILL_LENGTH, 1'b0);
      last_length = int'(FILL_LENGTH);
      send_read(9'd511);
      send_release();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: write_codes(16'd1, 16'd2, 16'd3);
            1: write_codes(16'h0000, 16'hFFFF, 16'h8000);
            2: write_codes(16'hFFFF, 16'h0000, 16'h7FFF);
            // equal codes: display wins, then touch
            3: write_codes(16'h00AA, 16'h00AA, 16'h00AA);
            5: write_codes(16'h5555, 16'h5555, 16'hAAAA);
            7: write_codes(16'hFFFF, 16'hFFFF, 16'h0000);
            default: write_codes(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         idle_mode <= idle_mode_type'(phase % 4);
         // phase four runs without idling; start the long response hold-off there
         if (phase == 4) hold_trigger <= 1'b1;
         phase_start = beat_count;
         while (beat_count - phase_start < RANDOM_ITEMS / PHASE_COUNT) random_burst();
      end

      // Drain: wait for every response, then give the pipeline time to show
      // any extra beat.
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/swfr_pkg.sv
rtl/sync_word_frame_receiver.sv
verif/sync_word_frame_receiver_checker.sv
verif/tb.sv
